// ===== rtl/core/track_static_and_heading_check_assert.svh =====
// Assertion macros for the static and heading check block
`ifndef TRACK_STATIC_AND_HEADING_CHECK_ASSERT_SVH
`define TRACK_STATIC_AND_HEADING_CHECK_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define TSHC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define TSHC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define TSHC_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define TSHC_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/core/tshc_pkg.sv =====
// Shared types, constants and tables of the static and heading check block
package tshc_pkg;
    localparam int unsigned WINDOW_DEF   = 6;
    localparam int unsigned QUEUE_DEPTH  = 2;
    localparam int unsigned CORDIC_STEPS = 16;

    localparam logic signed [20:0] PI_Q16     = 21'sd205887;
    localparam logic signed [16:0] TWO_PI_Q12 = 17'sd25736;

    localparam logic [15:0] POS_LIMIT_RST   = 16'd96;
    localparam logic [15:0] SPEED_LIMIT_RST = 16'd512;
    localparam logic [14:0] YAW_LIMIT_RST   = 15'd1638;

    localparam logic [1:0] REG_POS   = 2'd0;
    localparam logic [1:0] REG_SPEED = 2'd1;
    localparam logic [1:0] REG_YAW   = 2'd2;

    typedef struct packed {
        logic signed [15:0] vel_x;
        logic signed [15:0] vel_y;
        logic               is_pedestrian;
        logic signed [15:0] yaw_in;
        logic               window_full;
    } t_tshc_obs;

    typedef struct packed {
        logic               window_full;
        logic               obj_static;
        logic signed [15:0] yaw_out;
        logic               yaw_replaced;
    } t_tshc_res;

    typedef struct packed {
        logic [15:0] position_limit;
        logic [15:0] speed_limit;
        logic [14:0] yaw_limit;
    } t_tshc_cfg;

    typedef struct packed {
        logic full;
        logic empty;
    } t_tshc_qstat;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_MDISP,
        BK_MSPD,
        BK_MLIM,
        BK_HYST,
        BK_ROW,
        BK_PAIR,
        BK_FLUSH,
        BK_CINIT,
        BK_CORDIC,
        BK_FIN,
        BK_OUT
    } t_bk_state;

    function automatic logic signed [20:0] atan_q16(input logic [3:0] i);
        logic signed [20:0] v;
        unique case (i)
            4'd0:  v = 21'sd51472;
            4'd1:  v = 21'sd30386;
            4'd2:  v = 21'sd16055;
            4'd3:  v = 21'sd8150;
            4'd4:  v = 21'sd4091;
            4'd5:  v = 21'sd2047;
            4'd6:  v = 21'sd1024;
            4'd7:  v = 21'sd512;
            4'd8:  v = 21'sd256;
            4'd9:  v = 21'sd128;
            4'd10: v = 21'sd64;
            4'd11: v = 21'sd32;
            4'd12: v = 21'sd16;
            4'd13: v = 21'sd8;
            4'd14: v = 21'sd4;
            4'd15: v = 21'sd2;
        endcase
        return v;
    endfunction
endpackage

// ===== rtl/core/tshc_if.sv =====
// Observation and result channel interfaces
interface tshc_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
    logic               is_pedestrian;
    logic signed [15:0] yaw_in;
    modport source(output valid, pos_x, pos_y, vel_x, vel_y, is_pedestrian, yaw_in,
                   input ready);
    modport sink(input valid, pos_x, pos_y, vel_x, vel_y, is_pedestrian, yaw_in,
                 output ready);
endinterface

interface tshc_out_if;
    logic               valid;
    logic               ready;
    logic               window_full;
    logic               obj_static;
    logic signed [15:0] yaw_out;
    logic               yaw_replaced;
    modport source(output valid, window_full, obj_static, yaw_out, yaw_replaced,
                   input ready);
    modport sink(input valid, window_full, obj_static, yaw_out, yaw_replaced,
                 output ready);
endinterface

// ===== rtl/core/tshc_front.sv =====
// Front end: accept observations, shift the position window, enqueue work
module tshc_front
    import tshc_pkg::*;
#(
    parameter int unsigned WINDOW = WINDOW_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    tshc_in_if.sink                  i_in,
    input  t_tshc_qstat              i_qstat,
    output logic                     o_push,
    output logic [WINDOW-1:0][15:0]  o_wx,
    output logic [WINDOW-1:0][15:0]  o_wy,
    output t_tshc_obs                o_obs
);
    localparam int unsigned FC_W = $clog2(WINDOW + 1);

    logic [WINDOW-1:0][15:0] r_wx, n_wx;
    logic [WINDOW-1:0][15:0] r_wy, n_wy;
    logic [FC_W-1:0]         r_fill, n_fill;

    assign i_in.ready = !i_qstat.full;
    assign o_push     = i_in.valid && i_in.ready;

    always_comb begin
        n_wx   = {i_in.pos_x, r_wx[WINDOW-1:1]};
        n_wy   = {i_in.pos_y, r_wy[WINDOW-1:1]};
        n_fill = (r_fill == FC_W'(WINDOW)) ? r_fill : r_fill + FC_W'(1);
    end

    assign o_wx = n_wx;
    assign o_wy = n_wy;

    always_comb begin
        o_obs.vel_x         = i_in.vel_x;
        o_obs.vel_y         = i_in.vel_y;
        o_obs.is_pedestrian = i_in.is_pedestrian;
        o_obs.yaw_in        = i_in.yaw_in;
        o_obs.window_full   = (r_fill >= FC_W'(WINDOW - 1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (o_push) begin
            r_fill <= n_fill;
        end
        if (o_push) begin
            r_wx <= n_wx;
            r_wy <= n_wy;
        end
    end
endmodule

// ===== rtl/core/tshc_fifo.sv =====
// Short queue between front and back end
module tshc_fifo
    import tshc_pkg::*;
#(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output t_tshc_qstat      o_stat
);
    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wp, n_wp, r_rp, n_rp;
    logic [CW-1:0]    r_cnt, n_cnt;

    always_comb begin
        n_wp  = (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + PW'(1);
        n_rp  = (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + PW'(1);
        n_cnt = r_cnt + CW'(i_push) - CW'(i_pop);
    end

    assign o_data       = r_mem[r_rp];
    assign o_stat.full  = (r_cnt == CW'(DEPTH));
    assign o_stat.empty = (r_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= n_wp;
            if (i_pop)  r_rp <= n_rp;
            r_cnt <= n_cnt;
        end
        if (i_push) r_mem[r_wp] <= i_data;
    end
endmodule

// ===== rtl/core/tshc_back.sv =====
// Back end: hysteresis, farthest pair scan, CORDIC heading and result register
`include "track_static_and_heading_check_assert.svh"
module tshc_back
    import tshc_pkg::*;
#(
    parameter int unsigned WINDOW = WINDOW_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_tshc_qstat              i_qstat,
    input  logic [WINDOW-1:0][15:0]  i_wx,
    input  logic [WINDOW-1:0][15:0]  i_wy,
    input  t_tshc_obs                i_obs,
    input  t_tshc_cfg                i_cfg,
    output logic                     o_pop,
    tshc_out_if.source               o_out
);
    localparam int unsigned IW = $clog2(WINDOW);

    t_bk_state               r_state, n_state;
    logic [WINDOW-1:0][15:0] r_wx, r_wy;
    t_tshc_obs               r_obs;
    logic [1:0]              r_quiet, n_quiet, r_busy, n_busy;
    logic                    r_static, n_static;
    logic [31:0]             r_p0, r_p1;
    logic [32:0]             r_disp2, r_spd2;
    logic [IW-1:0]           r_ci, n_ci, r_cj, n_cj;
    logic [15:0]             r_pjx, r_pjy;
    logic                    r_tv;
    logic signed [16:0]      r_tdx, r_tdy;
    logic [32:0]             r_best, n_best;
    logic signed [16:0]      r_bdx, n_bdx, r_bdy, n_bdy;
    logic signed [35:0]      r_cx, n_cx, r_cy, n_cy;
    logic signed [20:0]      r_cz, n_cz;
    logic [3:0]              r_step;
    logic                    r_zero;
    logic signed [15:0]      r_yres, n_yres;
    logic                    r_repl, n_repl;
    t_tshc_res               r_out;
    logic                    r_ov;

    logic signed [16:0] m_a, m_b;
    logic signed [33:0] sq0, sq1;
    logic [IW-1:0]      rd_idx;
    logic [15:0]        rd_x, rd_y;
    logic signed [16:0] dif_x, dif_y;
    logic [32:0]        psum;
    logic               quiet, out_free, last_i, last_j;
    logic [1:0]         q_inc, b_inc;
    logic signed [16:0] ax, ay;
    logic signed [35:0] xs, ys;
    logic signed [20:0] zr;
    logic signed [16:0] hr, hd;
    logic signed [17:0] ydif;
    logic [17:0]        yabs;
    logic               yaw_ok;

    assign out_free = !r_ov || o_out.ready;
    assign last_i   = (r_ci == r_cj - IW'(1));
    assign last_j   = (r_cj == IW'(WINDOW - 1));
    assign rd_idx   = (r_state == BK_ROW) ? r_cj : r_ci;
    assign rd_x     = r_wx[rd_idx];
    assign rd_y     = r_wy[rd_idx];
    assign dif_x    = $signed({rd_x[15], rd_x}) - $signed({r_pjx[15], r_pjx});
    assign dif_y    = $signed({rd_y[15], rd_y}) - $signed({r_pjy[15], r_pjy});
    assign psum     = {1'b0, r_p0} + {1'b0, r_p1};
    assign sq0      = m_a * m_a;
    assign sq1      = m_b * m_b;
    assign o_pop    = (r_state == BK_IDLE) && !i_qstat.empty;
    assign yaw_ok   = $signed({1'b0, r_out.yaw_out}) < TWO_PI_Q12;

    always_comb begin
        unique case (r_state)
            BK_MDISP: begin
                m_a = $signed({r_wx[WINDOW-1][15], r_wx[WINDOW-1]})
                    - $signed({r_wx[0][15], r_wx[0]});
                m_b = $signed({r_wy[WINDOW-1][15], r_wy[WINDOW-1]})
                    - $signed({r_wy[0][15], r_wy[0]});
            end
            BK_MSPD: begin
                m_a = {r_obs.vel_x[15], r_obs.vel_x};
                m_b = {r_obs.vel_y[15], r_obs.vel_y};
            end
            BK_MLIM: begin
                m_a = $signed({1'b0, i_cfg.position_limit});
                m_b = $signed({1'b0, i_cfg.speed_limit});
            end
            default: begin
                m_a = dif_x;
                m_b = dif_y;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_IDLE:   if (!i_qstat.empty) n_state = i_obs.window_full ? BK_MDISP : BK_OUT;
            BK_MDISP:  n_state = BK_MSPD;
            BK_MSPD:   n_state = BK_MLIM;
            BK_MLIM:   n_state = BK_HYST;
            BK_HYST:   n_state = r_obs.is_pedestrian ? BK_ROW : BK_OUT;
            BK_ROW:    n_state = BK_PAIR;
            BK_PAIR:   if (last_i) n_state = last_j ? BK_FLUSH : BK_ROW;
            BK_FLUSH:  n_state = BK_CINIT;
            BK_CINIT:  n_state = BK_CORDIC;
            BK_CORDIC: if (r_step == 4'(CORDIC_STEPS - 1)) n_state = BK_FIN;
            BK_FIN:    n_state = BK_OUT;
            BK_OUT:    if (out_free) n_state = BK_IDLE;
            default:   n_state = BK_IDLE;
        endcase
    end

    always_comb begin
        quiet    = (r_disp2 < {1'b0, r_p0}) && (r_spd2 < {1'b0, r_p1});
        q_inc    = (r_quiet == 2'd3) ? r_quiet : r_quiet + 2'd1;
        b_inc    = (r_busy == 2'd2) ? r_busy : r_busy + 2'd1;
        n_quiet  = r_quiet;
        n_busy   = r_busy;
        n_static = r_static;
        if (r_state == BK_HYST) begin
            if (quiet) begin
                n_quiet = q_inc;
                n_busy  = 2'd0;
                if (q_inc == 2'd2) n_static = 1'b1;
            end else begin
                n_busy = b_inc;
                if (b_inc >= 2'd2) begin
                    n_static = 1'b0;
                    n_quiet  = 2'd0;
                end
            end
        end
    end

    always_comb begin
        n_ci   = r_ci;
        n_cj   = r_cj;
        n_best = r_best;
        n_bdx  = r_bdx;
        n_bdy  = r_bdy;
        if (r_state == BK_HYST) begin
            n_cj   = IW'(1);
            n_best = '0;
            n_bdx  = '0;
            n_bdy  = '0;
        end
        if (r_state == BK_ROW) n_ci = '0;
        if (r_state == BK_PAIR) begin
            n_ci = r_ci + IW'(1);
            if (last_i && !last_j) n_cj = r_cj + IW'(1);
        end
        if (r_tv && (psum > r_best)) begin
            n_best = psum;
            n_bdx  = -r_tdx;
            n_bdy  = -r_tdy;
        end
    end

    always_comb begin
        ax   = r_bdx[16] ? -r_bdx : r_bdx;
        ay   = r_bdx[16] ? -r_bdy : r_bdy;
        xs   = r_cx >>> r_step;
        ys   = r_cy >>> r_step;
        n_cx = r_cx;
        n_cy = r_cy;
        n_cz = r_cz;
        if (r_state == BK_CINIT) begin
            n_cx = $signed({{3{ax[16]}}, ax, 16'd0});
            n_cy = $signed({{3{ay[16]}}, ay, 16'd0});
            n_cz = r_bdx[16] ? PI_Q16 : '0;
        end else if (r_state == BK_CORDIC) begin
            if (!r_cy[35]) begin
                n_cx = r_cx + ys;
                n_cy = r_cy - xs;
                n_cz = r_cz + atan_q16(r_step);
            end else begin
                n_cx = r_cx - ys;
                n_cy = r_cy + xs;
                n_cz = r_cz - atan_q16(r_step);
            end
        end
    end

    always_comb begin
        zr = r_cz + 21'sd8;
        hr = $signed(zr[20:4]);
        if (hr < 0) begin
            hd = hr + TWO_PI_Q12;
        end else if (hr >= TWO_PI_Q12) begin
            hd = hr - TWO_PI_Q12;
        end else begin
            hd = hr;
        end
        if (r_zero) hd = '0;
        ydif   = $signed({hd[16], hd}) - $signed({{2{r_obs.yaw_in[15]}}, r_obs.yaw_in});
        yabs   = ydif[17] ? 18'(-ydif) : 18'(ydif);
        n_yres = r_yres;
        n_repl = r_repl;
        if (o_pop) begin
            n_yres = i_obs.yaw_in;
            n_repl = 1'b0;
        end else if ((r_state == BK_FIN) && (yabs > {3'b0, i_cfg.yaw_limit})) begin
            n_yres = hd[15:0];
            n_repl = 1'b1;
        end
    end

    assign o_out.valid        = r_ov;
    assign o_out.window_full  = r_out.window_full;
    assign o_out.obj_static   = r_out.obj_static;
    assign o_out.yaw_out      = r_out.yaw_out;
    assign o_out.yaw_replaced = r_out.yaw_replaced;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= BK_IDLE;
            r_quiet  <= '0;
            r_busy   <= '0;
            r_static <= 1'b0;
            r_tv     <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_quiet  <= n_quiet;
            r_busy   <= n_busy;
            r_static <= n_static;
            r_tv     <= (r_state == BK_PAIR);
            if ((r_state == BK_OUT) && out_free) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
        end
        if (o_pop) begin
            r_wx  <= i_wx;
            r_wy  <= i_wy;
            r_obs <= i_obs;
        end
        r_p0 <= sq0[31:0];
        r_p1 <= sq1[31:0];
        if (r_state == BK_MSPD) r_disp2 <= psum;
        if (r_state == BK_MLIM) r_spd2  <= psum;
        if (r_state == BK_ROW) begin
            r_pjx <= rd_x;
            r_pjy <= rd_y;
        end
        r_tdx  <= dif_x;
        r_tdy  <= dif_y;
        r_ci   <= n_ci;
        r_cj   <= n_cj;
        r_best <= n_best;
        r_bdx  <= n_bdx;
        r_bdy  <= n_bdy;
        r_cx   <= n_cx;
        r_cy   <= n_cy;
        r_cz   <= n_cz;
        r_step <= (r_state == BK_CORDIC) ? r_step + 4'd1 : 4'd0;
        if (r_state == BK_CINIT) r_zero <= (r_bdx == '0) && (r_bdy == '0);
        r_yres <= n_yres;
        r_repl <= n_repl;
        if ((r_state == BK_OUT) && out_free) begin
            r_out.window_full  <= r_obs.window_full;
            r_out.obj_static   <= r_static;
            r_out.yaw_out      <= r_yres;
            r_out.yaw_replaced <= r_repl;
        end
    end

    `TSHC_ASSERT_IMP(a_repl_full, i_clk, i_rst_n, r_ov && r_out.yaw_replaced, r_out.window_full)
    `TSHC_ASSERT_IMP(a_pair_order, i_clk, i_rst_n, r_state == BK_PAIR, r_ci < r_cj)
    `TSHC_ASSERT_NXT(a_flush_drain, i_clk, i_rst_n, r_state == BK_FLUSH, !r_tv)
    `TSHC_ASSERT_IMP(a_repl_range, i_clk, i_rst_n, r_ov && r_out.yaw_replaced, yaw_ok)
endmodule

// ===== rtl/core/track_static_and_heading_check.sv =====
// Top level: configuration registers, front end, queue and back end
// Flow: an observation before the window is full goes straight to the output;
//   a full window of a non-pedestrian adds the displacement, speed and hysteresis
//   steps; a pedestrian also runs the one-pair-a-cycle scan and the CORDIC.
// Throughput: one observation per back end pass; a two-entry queue decouples
//   the front end, which takes one observation per cycle while the queue has room.
// Reset: synchronous active low; clears fill count, hysteresis and handshakes, loads limit defaults.
module track_static_and_heading_check
    import tshc_pkg::*;
#(
    parameter int unsigned WINDOW = WINDOW_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tshc_in_if.sink     i_in,
    tshc_out_if.source  o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int unsigned OBS_W = $bits(t_tshc_obs);
    localparam int unsigned ENT_W = 2 * 16 * WINDOW + OBS_W;

    t_tshc_cfg               r_cfg;
    t_tshc_qstat             qstat;
    logic                    push, pop;
    logic [WINDOW-1:0][15:0] f_wx, f_wy, b_wx, b_wy;
    t_tshc_obs               f_obs, b_obs;
    logic [ENT_W-1:0]        q_in, q_out;
    logic                    wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_comb begin
        unique case (paddr[3:2])
            REG_POS:   prdata = {16'd0, r_cfg.position_limit};
            REG_SPEED: prdata = {16'd0, r_cfg.speed_limit};
            REG_YAW:   prdata = {17'd0, r_cfg.yaw_limit};
            default:   prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.position_limit <= POS_LIMIT_RST;
            r_cfg.speed_limit    <= SPEED_LIMIT_RST;
            r_cfg.yaw_limit      <= YAW_LIMIT_RST;
        end else if (wr_en) begin
            unique case (paddr[3:2])
                REG_POS:   r_cfg.position_limit <= pwdata[15:0];
                REG_SPEED: r_cfg.speed_limit    <= pwdata[15:0];
                REG_YAW:   r_cfg.yaw_limit      <= pwdata[14:0];
                default:   r_cfg <= r_cfg;
            endcase
        end
    end

    tshc_front #(.WINDOW(WINDOW)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_qstat (qstat),
        .o_push  (push),
        .o_wx    (f_wx),
        .o_wy    (f_wy),
        .o_obs   (f_obs)
    );

    assign q_in = {f_wx, f_wy, f_obs};
    assign {b_wx, b_wy, b_obs} = q_out;

    tshc_fifo #(.WIDTH(ENT_W), .DEPTH(QUEUE_DEPTH)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (q_in),
        .i_pop   (pop),
        .o_data  (q_out),
        .o_stat  (qstat)
    );

    tshc_back #(.WINDOW(WINDOW)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_qstat (qstat),
        .i_wx    (b_wx),
        .i_wy    (b_wy),
        .i_obs   (b_obs),
        .i_cfg   (r_cfg),
        .o_pop   (pop),
        .o_out   (o_out)
    );
endmodule
